FILE: hw/rtl/array_statistics_engine_unit_assert.svh
// Assertion macros used by the checker file ase_checker.sv.
`ifndef ARRAY_STATISTICS_ENGINE_UNIT_ASSERT_SVH
`define ARRAY_STATISTICS_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define ASE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ase assertion failed");

// next-cycle implication
`define ASE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ase assertion failed");

`endif

FILE: hw/rtl/ase_pkg.sv
package ase_pkg;

    localparam int ASE_MAX_ELEMENTS = 1024;

    // request kinds
    localparam logic REQ_PUSH   = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    // result status codes
    localparam logic STS_OK    = 1'b0;
    localparam logic STS_EMPTY = 1'b1;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH,
        OP_LOAD,
        OP_CMP,
        OP_MODE,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_MEAN,
        OP_DEV,
        OP_OUT,
        OP_OUT_EMPTY
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] value;
    } t_cmd;

    typedef struct packed {
        logic empty;
    } t_sts;

endpackage

FILE: hw/rtl/ase_req_if.sv
interface ase_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] value;

    modport source (output valid, req_type, value, input ready);
    modport sink (input valid, req_type, value, output ready);
endinterface

FILE: hw/rtl/ase_res_if.sv
interface ase_res_if;
    logic               valid;
    logic               ready;
    logic               status;
    logic               overflowed;
    logic signed [31:0] largest_value;
    logic [9:0]         max_position;
    logic signed [31:0] smallest_value;
    logic [9:0]         min_position;
    logic signed [31:0] mode_value;
    logic [10:0]        mode_count;
    logic signed [47:0] mean_q16;
    logic [47:0]        max_deviation_q16;

    modport source (output valid, status, overflowed, largest_value, max_position,
                    smallest_value, min_position, mode_value, mode_count, mean_q16,
                    max_deviation_q16, input ready);
    modport sink (input valid, status, overflowed, largest_value, max_position,
                  smallest_value, min_position, mode_value, mode_count, mean_q16,
                  max_deviation_q16, output ready);
endinterface

FILE: hw/rtl/ase_datapath.sv
module ase_datapath
    import ase_pkg::*;
#(
    parameter int MAX_ELEMENTS = ASE_MAX_ELEMENTS,
    localparam int AW = $clog2(MAX_ELEMENTS),
    localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic [AW-1:0]      i_rd_addr,
    output t_sts               o_sts,
    output logic [CW-1:0]      o_count,
    output logic               o_status,
    output logic               o_overflowed,
    output logic signed [31:0] o_largest_value,
    output logic [9:0]         o_max_position,
    output logic signed [31:0] o_smallest_value,
    output logic [9:0]         o_min_position,
    output logic signed [31:0] o_mode_value,
    output logic [10:0]        o_mode_count,
    output logic signed [47:0] o_mean_q16,
    output logic [47:0]        o_max_deviation_q16
);

    localparam int SW = 32 + AW;   // sum width
    localparam int DW = SW + 16;   // dividend width

    logic [31:0]          r_mem [MAX_ELEMENTS];
    logic [31:0]          r_rdata;
    t_op                  r_rd_op;
    logic [AW-1:0]        r_rd_idx;
    logic [CW-1:0]        r_count;
    logic                 r_ovf;

    logic signed [31:0]   r_xi, r_maxv, r_minv, r_modev;
    logic [AW-1:0]        r_maxp, r_minp;
    logic [CW-1:0]        r_cnt, r_modec;
    logic signed [SW-1:0] r_sum;
    logic [DW-1:0]        r_dvd;
    logic [CW-1:0]        r_rem;
    logic                 r_neg;
    logic signed [48:0]   r_mean;
    logic [49:0]          r_maxdev;

    logic signed [31:0]   x;
    logic [SW-1:0]        mag;
    logic [CW:0]          rem_sh;
    logic                 q_bit;
    logic signed [49:0]   dev;
    logic [49:0]          dev_abs;

    assign o_count     = r_count;
    assign o_sts.empty = (r_count == '0);

    // element store
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_PUSH && r_count < CW'(MAX_ELEMENTS)) begin
            r_mem[r_count[AW-1:0]] <= i_cmd.value;
        end
        r_rdata <= r_mem[i_rd_addr];
    end

    // fill count and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.op == OP_PUSH) begin
            if (r_count < CW'(MAX_ELEMENTS)) r_count <= r_count + CW'(1);
            else r_ovf <= 1'b1;
        end
    end

    // read op is registered alongside its read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_op <= OP_NONE;
        end else begin
            r_rd_op <= (i_cmd.op == OP_LOAD || i_cmd.op == OP_CMP || i_cmd.op == OP_DEV)
                       ? i_cmd.op : OP_NONE;
        end
        r_rd_idx <= i_rd_addr;
    end

    // arithmetic helpers
    assign x       = $signed(r_rdata);
    assign mag     = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign rem_sh  = {r_rem, r_dvd[DW-1]};
    assign q_bit   = (rem_sh >= {1'b0, r_count});
    assign dev     = $signed({{2{x[31]}}, x, 16'b0}) - 50'(r_mean);
    assign dev_abs = dev[49] ? 50'(-dev) : 50'(dev);

    // statistics registers
    always_ff @(posedge i_clk) begin
        case (r_rd_op)
            OP_LOAD: begin
                r_xi  <= x;
                r_cnt <= '0;
                if (r_rd_idx == '0) begin
                    r_sum   <= SW'(x);
                    r_maxv  <= x;
                    r_minv  <= x;
                    r_maxp  <= '0;
                    r_minp  <= '0;
                    r_modev <= x;
                    r_modec <= '0;
                end else begin
                    r_sum <= r_sum + SW'(x);
                    if (x > r_maxv) begin
                        r_maxv <= x;
                        r_maxp <= r_rd_idx;
                    end
                    if (x < r_minv) begin
                        r_minv <= x;
                        r_minp <= r_rd_idx;
                    end
                end
            end
            OP_CMP: begin
                if (r_rdata == r_xi) r_cnt <= r_cnt + CW'(1);
            end
            OP_DEV: begin
                if (dev_abs > r_maxdev) r_maxdev <= dev_abs;
            end
            default: begin
            end
        endcase

        case (i_cmd.op)
            OP_MODE: begin
                if (r_cnt > r_modec || (r_cnt == r_modec && r_xi > r_modev)) begin
                    r_modec <= r_cnt;
                    r_modev <= r_xi;
                end
            end
            OP_DIV_INIT: begin
                r_dvd    <= {mag, 16'b0};
                r_rem    <= '0;
                r_neg    <= r_sum[SW-1];
                r_maxdev <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= q_bit ? CW'(rem_sh - {1'b0, r_count}) : CW'(rem_sh);
                r_dvd <= {r_dvd[DW-2:0], q_bit};
            end
            OP_MEAN: begin
                r_mean <= r_neg ? -$signed(r_dvd[48:0]) : $signed(r_dvd[48:0]);
            end
            OP_OUT: begin
                o_status            <= STS_OK;
                o_overflowed        <= r_ovf;
                o_largest_value     <= r_maxv;
                o_max_position      <= 10'(r_maxp);
                o_smallest_value    <= r_minv;
                o_min_position      <= 10'(r_minp);
                o_mode_value        <= r_modev;
                o_mode_count        <= 11'(r_modec);
                o_mean_q16          <= r_mean[47:0];
                o_max_deviation_q16 <= r_maxdev[47:0];
            end
            OP_OUT_EMPTY: begin
                o_status            <= STS_EMPTY;
                o_overflowed        <= r_ovf;
                o_largest_value     <= '0;
                o_max_position      <= '0;
                o_smallest_value    <= '0;
                o_min_position      <= '0;
                o_mode_value        <= '0;
                o_mode_count        <= '0;
                o_mean_q16          <= '0;
                o_max_deviation_q16 <= '0;
            end
            default: begin
            end
        endcase
    end

endmodule

FILE: hw/rtl/ase_ctrl.sv
module ase_ctrl
    import ase_pkg::*;
#(
    parameter int MAX_ELEMENTS = ASE_MAX_ELEMENTS,
    localparam int AW = $clog2(MAX_ELEMENTS),
    localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_req_type,
    input  logic [31:0]   i_in_value,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  t_sts          i_sts,
    input  logic [CW-1:0] i_count,
    output t_cmd          o_cmd,
    output logic [AW-1:0] o_rd_addr
);

    localparam int DW = 32 + AW + 16;
    localparam int KW = $clog2(DW);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_CMP, S_CWAIT, S_MODE, S_DINIT, S_DIV, S_MEAN, S_DEV, S_DWAIT, S_OUT
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_i, r_j;
    logic [KW-1:0] r_k;
    logic          r_out_valid;
    logic          accept;
    logic          i_last, j_last;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && o_in_ready;
    assign i_last      = (r_i + CW'(1)) == i_count;
    assign j_last      = (r_j + CW'(1)) == i_count;

    // command decode
    always_comb begin
        n_state     = r_state;
        o_cmd.op    = OP_NONE;
        o_cmd.value = i_in_value;
        o_rd_addr   = r_j[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_req_type == REQ_PUSH) o_cmd.op = OP_PUSH;
                    else if (i_sts.empty) o_cmd.op = OP_OUT_EMPTY;
                    else n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.op  = OP_LOAD;
                o_rd_addr = r_i[AW-1:0];
                n_state   = S_CMP;
            end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                if (j_last) n_state = S_CWAIT;
            end
            S_CWAIT: n_state = S_MODE;
            S_MODE: begin
                o_cmd.op = OP_MODE;
                n_state  = i_last ? S_DINIT : S_LOAD;
            end
            S_DINIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                if (r_k == KW'(DW - 1)) n_state = S_MEAN;
            end
            S_MEAN: begin
                o_cmd.op = OP_MEAN;
                n_state  = S_DEV;
            end
            S_DEV: begin
                o_cmd.op = OP_DEV;
                if (j_last) n_state = S_DWAIT;
            end
            S_DWAIT: n_state = S_OUT;
            S_OUT: begin
                o_cmd.op = OP_OUT;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state, loop counters, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_i <= '0;
                    if (o_cmd.op == OP_OUT_EMPTY) r_out_valid <= 1'b1;
                end
                S_LOAD:  r_j <= '0;
                S_CMP:   r_j <= r_j + CW'(1);
                S_MODE:  r_i <= r_i + CW'(1);
                S_DINIT: r_k <= '0;
                S_DIV:   r_k <= r_k + KW'(1);
                S_MEAN:  r_j <= '0;
                S_DEV:   r_j <= r_j + CW'(1);
                S_OUT:   r_out_valid <= 1'b1;
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/array_statistics_engine_unit.sv
// Push: one word per cycle while idle, no result. Finish on an empty store:
// result valid in the cycle after the word is taken. Finish on n values: the result
// follows n mode passes over the store, a 1-bit-per-cycle divider of 48+AW
// steps and n deviation reads.
// No words are taken while a finish is computing or a result waits.
// Synchronous active-low reset clears count, overflow flag and control, not the store.
module array_statistics_engine_unit
    import ase_pkg::*;
#(
    parameter int MAX_ELEMENTS = ASE_MAX_ELEMENTS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ase_req_if.sink   i_req,
    ase_res_if.source o_res
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    t_cmd          cmd;
    t_sts          sts;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] count;

    ase_ctrl #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_req.valid),
        .i_in_req_type (i_req.req_type),
        .i_in_value    (i_req.value),
        .o_in_ready    (i_req.ready),
        .o_out_valid   (o_res.valid),
        .i_out_ready   (o_res.ready),
        .i_sts         (sts),
        .i_count       (count),
        .o_cmd         (cmd),
        .o_rd_addr     (rd_addr)
    );

    ase_datapath #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_rd_addr           (rd_addr),
        .o_sts               (sts),
        .o_count             (count),
        .o_status            (o_res.status),
        .o_overflowed        (o_res.overflowed),
        .o_largest_value     (o_res.largest_value),
        .o_max_position      (o_res.max_position),
        .o_smallest_value    (o_res.smallest_value),
        .o_min_position      (o_res.min_position),
        .o_mode_value        (o_res.mode_value),
        .o_mode_count        (o_res.mode_count),
        .o_mean_q16          (o_res.mean_q16),
        .o_max_deviation_q16 (o_res.max_deviation_q16)
    );

endmodule

FILE: hw/rtl/ase_checker.sv
`include "array_statistics_engine_unit_assert.svh"

module ase_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_status,
    input logic signed [31:0] i_largest_value,
    input logic signed [31:0] i_smallest_value,
    input logic [10:0]        i_mode_count,
    input logic [47:0]        i_max_deviation_q16
);

    // a waiting result holds
    `ASE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // no words taken while a result is stuck
    `ASE_ASSERT_NOW(a_in_block, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready)
    // empty result carries zeros
    `ASE_ASSERT_NOW(a_empty_zero, i_clk, i_rst_n, i_out_valid && i_status,
        i_mode_count == '0 && i_max_deviation_q16 == '0 && i_largest_value == '0)
    // good result is consistent
    `ASE_ASSERT_NOW(a_ok_order, i_clk, i_rst_n, i_out_valid && !i_status,
        i_largest_value >= i_smallest_value)

endmodule

bind array_statistics_engine_unit ase_checker u_ase_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_ready          (i_req.ready),
    .i_out_valid         (o_res.valid),
    .i_out_ready         (o_res.ready),
    .i_status            (o_res.status),
    .i_largest_value     (o_res.largest_value),
    .i_smallest_value    (o_res.smallest_value),
    .i_mode_count        (o_res.mode_count),
    .i_max_deviation_q16 (o_res.max_deviation_q16)
);

FILE: sim/array_statistics_engine_unit_tb.sv
`timescale 1ns / 1ps

module array_statistics_engine_unit_tb;
    import ase_pkg::*;

    localparam int CAPACITY = ASE_MAX_ELEMENTS;

    typedef struct {
        logic               status;
        logic               overflowed;
        logic signed [31:0] largest_value;
        logic [9:0]         max_position;
        logic signed [31:0] smallest_value;
        logic [9:0]         min_position;
        logic signed [31:0] mode_value;
        logic [10:0]        mode_count;
        logic signed [47:0] mean_q16;
        logic [47:0]        max_deviation_q16;
    } t_stats;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ase_req_if req_ch ();
    ase_res_if res_ch ();

    array_statistics_engine_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // shadow of the block's store and flags
    logic signed [31:0] stored_values[$];
    logic               dropped_push;
    t_stats             pending_stats[$];
    int                 error_count = 0;
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;

    // statistics over the values stored so far
    function automatic t_stats predict_finish();
        t_stats      s;
        int          n;
        int          occur[int];
        longint      sum;
        longint      mean;
        longint      dev;
        longint      maxdev;
        longint unsigned mag;
        longint unsigned q;
        n = stored_values.size();
        s = '{default: '0};
        s.overflowed = dropped_push;
        if (n == 0) begin
            s.status = STS_EMPTY;
            return s;
        end
        s.status = STS_OK;
        s.largest_value = stored_values[0];
        s.smallest_value = stored_values[0];
        sum = 0;
        for (int i = 0; i < n; i++) begin
            sum += longint'(stored_values[i]);
            if (stored_values[i] > s.largest_value) begin
                s.largest_value = stored_values[i];
                s.max_position = i[9:0];
            end
            if (stored_values[i] < s.smallest_value) begin
                s.smallest_value = stored_values[i];
                s.min_position = i[9:0];
            end
            if (occur.exists(int'(stored_values[i]))) occur[int'(stored_values[i])]++;
            else occur[int'(stored_values[i])] = 1;
        end
        // most frequent, larger value on ties
        s.mode_value = stored_values[0];
        s.mode_count = 0;
        foreach (occur[v]) begin
            if (occur[v] > s.mode_count ||
                (occur[v] == s.mode_count && v > s.mode_value)) begin
                s.mode_count = occur[v];
                s.mode_value = v;
            end
        end
        // Q16 mean, truncated toward zero
        mag = (sum < 0) ? longint'(-sum) : longint'(sum);
        q = (mag << 16) / longint'(n);
        mean = (sum < 0) ? -longint'(q) : longint'(q);
        maxdev = 0;
        for (int i = 0; i < n; i++) begin
            dev = longint'(stored_values[i]) * 65536 - mean;
            if (dev < 0) dev = -dev;
            if (dev > maxdev) maxdev = dev;
        end
        s.mean_q16 = mean[47:0];
        s.max_deviation_q16 = maxdev[47:0];
        return s;
    endfunction

    // value mix: repeats for the mode, extremes, full-range noise
    function automatic logic signed [31:0] pick_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return $signed($urandom_range(8)) - 4;
        if (sel < 55) begin
            case ($urandom_range(3))
                0: return 32'sh7fffffff;
                1: return 32'sh80000000;
                2: return 32'sh7ffffffe;
                default: return 32'sh80000001;
            endcase
        end
        return $urandom;
    endfunction

    // one request word; valid stays high across back-to-back words
    task automatic send_word(input logic kind, input logic signed [31:0] val);
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.value <= val;
        do @(posedge i_clk); while (!req_ch.ready);
        if (kind == REQ_FINISH) begin
            pending_stats.push_back(predict_finish());
        end else if (stored_values.size() < CAPACITY) begin
            stored_values.push_back(val);
        end else begin
            dropped_push = 1'b1;
        end
    endtask

    task automatic push_word(input logic signed [31:0] val);
        send_word(REQ_PUSH, val);
    endtask

    task automatic finish_word();
        send_word(REQ_FINISH, $urandom);
    endtask

    // sender holds off until every result is back
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_stats.size() != 0) @(posedge i_clk);
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_stats.size() == 0) begin
                $error("result word with no prediction waiting");
                error_count++;
            end else begin
                e = pending_stats.pop_front();
                check_field("status", e.status, res_ch.status);
                check_field("overflowed", e.overflowed, res_ch.overflowed);
                if (e.status == STS_OK || res_ch.status == STS_OK) begin
                    check_field("largest_value", e.largest_value, res_ch.largest_value);
                    check_field("max_position", e.max_position, res_ch.max_position);
                    check_field("smallest_value", e.smallest_value,
                                res_ch.smallest_value);
                    check_field("min_position", e.min_position, res_ch.min_position);
                    check_field("mode_value", e.mode_value, res_ch.mode_value);
                    check_field("mode_count", e.mode_count, res_ch.mode_count);
                    check_field("mean_q16", e.mean_q16, res_ch.mean_q16);
                    check_field("max_deviation_q16", e.max_deviation_q16,
                                res_ch.max_deviation_q16);
                end else begin
                    check_field("largest_value", 0, res_ch.largest_value);
                    check_field("max_position", 0, res_ch.max_position);
                    check_field("smallest_value", 0, res_ch.smallest_value);
                    check_field("min_position", 0, res_ch.min_position);
                    check_field("mode_value", 0, res_ch.mode_value);
                    check_field("mode_count", 0, res_ch.mode_count);
                    check_field("mean_q16", 0, res_ch.mean_q16);
                    check_field("max_deviation_q16", 0, res_ch.max_deviation_q16);
                end
            end
        end
    end

    // finish on an empty store, twice
    task automatic test_empty_finish();
        finish_word();
        finish_word();
    endtask

    // extremes, first-index positions, mode ties, repeated finish
    task automatic test_directed();
        push_word(32'sh7fffffff);
        push_word(32'sh80000000);
        push_word(0);
        push_word(-1);
        push_word(32'sh80000000);
        push_word(32'sh7fffffff);
        finish_word();
        push_word(5);
        push_word(5);
        push_word(-1);
        push_word(0);
        finish_word();
        finish_word();
        push_word(7);
        push_word(7);
        push_word(-1);
        push_word(32'sh7fffffff);
        push_word(32'sh7fffffff);
        finish_word();
    endtask

    // random words under one idling mix; finishes kept cheap while store is small
    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int words);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int k = 0; k < words; k++) begin
            if ($urandom_range(stored_values.size() < 64 ? 4 : 24) == 0) finish_word();
            else push_word(pick_value());
        end
        drain_results();
    endtask

    // fill the store, overrun it, then finish at full size
    task automatic test_overflow();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        while (stored_values.size() < CAPACITY) push_word(pick_value());
        for (int k = 0; k < 900; k++) push_word(pick_value());
        send_idle_pct = 13;
        recv_stall_pct = 13;
        finish_word();
        finish_word();
    endtask

    initial begin
        dropped_push = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_PUSH;
        req_ch.value = '0;
        res_ch.ready = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_finish();
        test_directed();
        drain_results();
        test_random_phase(0, 0, 110);
        test_random_phase(68, 0, 110);
        test_random_phase(0, 68, 110);
        test_random_phase(13, 13, 110);
        test_overflow();
        drain_results();
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && pending_stats.size() == 0) begin
            $display("array_statistics_engine_unit_tb: done, clean");
        end else begin
            $display("array_statistics_engine_unit_tb: done, errors");
        end
        $finish;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("array_statistics_engine_unit_tb: done, errors");
        $finish;
    end

endmodule
